FILE: hw/rtl/assert_macros.svh
// assertion macros used by the top level rtl file
// no dependencies; define ASSERT_OFF to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/rcpc_pkg.sv
// package for the rc pulse capture and calibrate block
// types, command codes and constants; no dependencies
package rcpc_pkg;
  localparam int NCH_MAX = 8;
  localparam int CHANNELS_DEF = 8;
  localparam int SLOPE_FRAC_DEF = 16;
  localparam int SLOPE_W = 24;
  localparam int OFF_W = 32;
  localparam logic [15:0] TIMER_TOP_RST = 16'd4001;
  localparam logic [7:0] ENABLE_RST = 8'hFF;
  localparam int SPAN_TARGET = 2000;

  typedef enum logic [2:0] {
    KIND_EDGE   = 3'd0,
    KIND_SCALE  = 3'd1,
    KIND_CSTART = 3'd2,
    KIND_CSAMP  = 3'd3,
    KIND_CFIN   = 3'd4,
    KIND_LOAD   = 3'd5
  } kind_t;

  typedef enum logic [0:0] {
    REG_TIMER_TOP = 1'b0,
    REG_ENABLE    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_OFFM,
    ST_OFFS,
    ST_SMUL,
    ST_SOUT
  } state_t;
endpackage

FILE: hw/rtl/rc_pulse_capture_calibrate.sv
// top level of the rc pulse capture and calibrate block
// depends on rcpc_pkg and assert_macros.svh
//
// Edge, calibration start, calibration sample and coefficient load commands
// complete in the cycle they are accepted, so the block is ready again on the
// next cycle. A scale command steps each channel through a multiply state
// and an output state. A calibration finish runs the shared restoring divider
// one quotient bit a cycle for each channel, after latching the span and
// before taking the quotient (a zero span skips the division), then goes
// through the offset multiply, offset store, scale multiply and output states.
// One 24x16 multiplier is shared by offset and scaling. Results leave through
// a single output register; a stalled output holds the sequencer.
`include "assert_macros.svh"
module rc_pulse_capture_calibrate import rcpc_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int SLOPE_FRAC_BITS = SLOPE_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic [7:0]         in_edge_flags,
  input  logic [15:0]        in_capture_time,
  input  logic [2:0]         in_target_channel,
  input  logic [SLOPE_W-1:0] in_load_slope,
  input  logic signed [OFF_W-1:0] in_load_offset,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_channel_index,
  output logic [15:0]        out_raw_width,
  output logic [15:0]        out_scaled_value,
  output logic               out_zero_span,
  output logic               out_last_of_run
);
  localparam int DW = 11 + SLOPE_FRAC_BITS;
  localparam int CNTW = $clog2(DW + 1);
  localparam logic [DW-1:0] DIVIDEND = DW'(SPAN_TARGET) << SLOPE_FRAC_BITS;
  localparam int RSH = (SLOPE_FRAC_BITS >= 16) ? SLOPE_FRAC_BITS - 16 : 0;
  localparam int LSH = (SLOPE_FRAC_BITS < 16) ? 16 - SLOPE_FRAC_BITS : 0;
  localparam int QW = 50;
  localparam logic [2:0] LAST_CH = 3'(CHANNELS - 1);
  localparam logic [SLOPE_W-1:0] SLOPE_ONE = SLOPE_W'(1) << SLOPE_FRAC_BITS;
  localparam logic [SLOPE_W-1:0] SLOPE_MAX = {SLOPE_W{1'b1}};
  localparam logic signed [QW-1:0] OFF_BASE = QW'(SPAN_TARGET) << 16;
  localparam logic signed [QW-1:0] OFF_MAXV = QW'(32'sh7FFFFFFF);
  localparam logic signed [QW-1:0] OFF_MINV = -(QW'(1) << 31);

  logic [15:0] timer_top_r;
  logic [7:0]  enable_r;
  logic [15:0] rise_r [NCH_MAX];
  logic [NCH_MAX-1:0] fall_r;
  logic [15:0] pw_r [NCH_MAX];
  logic [15:0] min_r [NCH_MAX];
  logic [15:0] max_r [NCH_MAX];
  logic [SLOPE_W-1:0] slope_r [NCH_MAX];
  logic signed [OFF_W-1:0] off_r [NCH_MAX];

  state_t state_r, state_nxt;
  logic [2:0] ch_r;
  logic       fin_r;
  logic       zs_r;
  logic [15:0] span_r;
  logic [DW-1:0] dvd_r, quo_r;
  logic [15:0] rem_r;
  logic [CNTW-1:0] cnt_r;
  logic [SLOPE_W-1:0] snew_r;
  logic [39:0] prod_r;

  logic in_xfer, slot_free, div_done;
  logic [16:0] trial;
  logic        qbit;
  logic [SLOPE_W-1:0] mul_a;
  logic [15:0] mul_b;
  logic signed [QW-1:0] qv, offv, sumv;
  logic [15:0] sat_sum;
  logic [SLOPE_W-1:0] slope_sat;
  logic [15:0] span_now;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;
  assign div_done = (cnt_r == CNTW'(DW));

  // divider step, shared multiplier operands and fixed-point conversions
  always_comb begin
    trial = {rem_r, dvd_r[DW-1]};
    qbit = (trial >= {1'b0, span_r});
    slope_sat = (32'(quo_r) > 32'(SLOPE_MAX)) ? SLOPE_MAX : SLOPE_W'(quo_r);
    span_now = (max_r[ch_r] >= min_r[ch_r]) ? (max_r[ch_r] - min_r[ch_r]) : 16'd0;
    mul_a = (state_r == ST_OFFM) ? snew_r : slope_r[ch_r];
    mul_b = (state_r == ST_OFFM) ? min_r[ch_r] : pw_r[ch_r];
    qv = (QW'(prod_r) >> RSH) << LSH;
    offv = OFF_BASE - qv;
    sumv = qv + QW'(off_r[ch_r]);
    if (sumv < 0) begin
      sat_sum = 16'd0;
    end else if (|sumv[QW-1:32]) begin
      sat_sum = 16'hFFFF;
    end else begin
      sat_sum = sumv[31:16];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_kind == KIND_CFIN) state_nxt = ST_DIV;
        else if (in_xfer && in_kind == KIND_SCALE) state_nxt = ST_SMUL;
      end
      ST_DIV: begin
        if (div_done || (cnt_r == '0 && !zs_r && span_now == 16'd0)) state_nxt = ST_OFFM;
      end
      ST_OFFM: state_nxt = ST_OFFS;
      ST_OFFS: state_nxt = ST_SMUL;
      ST_SMUL: state_nxt = ST_SOUT;
      ST_SOUT: begin
        if (slot_free) begin
          if (ch_r == LAST_CH) state_nxt = ST_IDLE;
          else if (fin_r) state_nxt = ST_DIV;
          else state_nxt = ST_SMUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_top_r <= TIMER_TOP_RST;
      enable_r <= ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TIMER_TOP: timer_top_r <= cfg_data;
        REG_ENABLE:    enable_r <= cfg_data[7:0];
        default:       timer_top_r <= timer_top_r;
      endcase
    end
  end

  // channel state, sequencer counters and divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH_MAX; c++) begin
        rise_r[c] <= 16'd0;
        pw_r[c] <= 16'd0;
        min_r[c] <= 16'd0;
        max_r[c] <= 16'd0;
        slope_r[c] <= SLOPE_ONE;
        off_r[c] <= '0;
      end
      fall_r <= '0;
      ch_r <= 3'd0;
      fin_r <= 1'b0;
      zs_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          ch_r <= 3'd0;
          zs_r <= 1'b0;
          fin_r <= (in_kind == KIND_CFIN);
          if (in_xfer) begin
            priority case (in_kind)
              KIND_EDGE: begin
                for (int c = 0; c < CHANNELS; c++) begin
                  if (in_edge_flags[c] && enable_r[c]) begin
                    if (!fall_r[c]) begin
                      rise_r[c] <= in_capture_time;
                      fall_r[c] <= 1'b1;
                    end else begin
                      if (rise_r[c] > in_capture_time)
                        pw_r[c] <= timer_top_r - rise_r[c] + in_capture_time;
                      else
                        pw_r[c] <= in_capture_time - rise_r[c];
                      fall_r[c] <= 1'b0;
                    end
                  end
                end
              end
              KIND_CSTART: begin
                for (int c = 0; c < CHANNELS; c++) begin
                  slope_r[c] <= SLOPE_ONE;
                  off_r[c] <= '0;
                  min_r[c] <= pw_r[c];
                  max_r[c] <= pw_r[c];
                end
              end
              KIND_CSAMP: begin
                for (int c = 0; c < CHANNELS; c++) begin
                  if (pw_r[c] > max_r[c]) max_r[c] <= pw_r[c];
                  if (pw_r[c] < min_r[c]) min_r[c] <= pw_r[c];
                end
              end
              KIND_LOAD: begin
                if (32'(in_target_channel) < CHANNELS) begin
                  slope_r[in_target_channel] <= in_load_slope;
                  off_r[in_target_channel] <= in_load_offset;
                end
              end
              default: fall_r <= fall_r;
            endcase
          end
          span_r <= 16'd0;
          cnt_r <= '0;
          rem_r <= 16'd0;
          dvd_r <= DIVIDEND;
          quo_r <= '0;
        end
        ST_DIV: begin
          // first cycle of a channel latches the span; cnt_r counts bits
          if (cnt_r == '0 && span_r == 16'd0 && !zs_r && span_now != 16'd0) begin
            span_r <= span_now;
            cnt_r <= CNTW'(1) - CNTW'(1);
            zs_r <= 1'b1;
          end
          if (zs_r) begin
            rem_r <= qbit ? 16'(trial - {1'b0, span_r}) : trial[15:0];
            dvd_r <= dvd_r << 1;
            quo_r <= {quo_r[DW-2:0], qbit};
            cnt_r <= cnt_r + CNTW'(1);
          end
          if (div_done || (cnt_r == '0 && !zs_r && span_now == 16'd0)) begin
            snew_r <= (span_now == 16'd0) ? SLOPE_MAX : slope_sat;
            zs_r <= (span_now == 16'd0);
          end
        end
        ST_OFFM: prod_r <= 40'(mul_a) * 40'(mul_b);
        ST_OFFS: begin
          slope_r[ch_r] <= snew_r;
          if (offv > OFF_MAXV) off_r[ch_r] <= 32'sh7FFFFFFF;
          else if (offv < OFF_MINV) off_r[ch_r] <= 32'sh80000000;
          else off_r[ch_r] <= offv[31:0];
        end
        ST_SMUL: prod_r <= 40'(mul_a) * 40'(mul_b);
        ST_SOUT: begin
          if (slot_free) begin
            ch_r <= ch_r + 3'd1;
            zs_r <= 1'b0;
            span_r <= 16'd0;
            cnt_r <= '0;
            rem_r <= 16'd0;
            dvd_r <= DIVIDEND;
            quo_r <= '0;
          end
        end
        default: ch_r <= ch_r;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == ST_SOUT && slot_free) begin
      out_valid <= 1'b1;
      out_channel_index <= ch_r;
      out_raw_width <= pw_r[ch_r];
      out_scaled_value <= sat_sum;
      out_zero_span <= fin_r && zs_r;
      out_last_of_run <= (ch_r == LAST_CH);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_ALWAYS(a_busy_not_ready, clk, rst_n, (state_r == ST_IDLE) || !in_ready)
  `ASSERT_ALWAYS(a_last_ch, clk, rst_n, !(out_valid && out_last_of_run) || out_channel_index == LAST_CH)
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, state_r == ST_SOUT && !slot_free, state_r == ST_SOUT)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_scaled_value))
endmodule
